// ----- design/aes128_pkg.sv -----
`default_nettype none
package aes128_pkg;

  localparam int ROUNDS = 10;
  localparam int ENC_KEYS = 11;
  localparam int DEC_KEYS = 9;
  localparam int ENC_AW = $clog2(ENC_KEYS);
  localparam int DEC_AW = $clog2(DEC_KEYS);
  localparam logic [7:0] RCON_FIRST = 8'h01;

  typedef enum logic [1:0] {
    ST_EXPAND,
    ST_IDLE,
    ST_RUN,
    ST_HOLD
  } state_t;

  typedef struct packed {
    logic        kind;
    logic [63:0] block_high;
    logic [63:0] block_low;
  } in_t;

  typedef struct packed {
    logic [63:0] result_high;
    logic [63:0] result_low;
  } out_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  function automatic logic [7:0] xt(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [127:0] mix_cols(input logic [127:0] s);
    logic [127:0] r;
    logic [7:0] a0, a1, a2, a3, t;
    for (int c = 0; c < 4; c++) begin
      a0 = s[32*c +: 8];
      a1 = s[32*c+8 +: 8];
      a2 = s[32*c+16 +: 8];
      a3 = s[32*c+24 +: 8];
      t = a0 ^ a1 ^ a2 ^ a3;
      r[32*c +: 8]    = a0 ^ t ^ xt(a0 ^ a1);
      r[32*c+8 +: 8]  = a1 ^ t ^ xt(a1 ^ a2);
      r[32*c+16 +: 8] = a2 ^ t ^ xt(a2 ^ a3);
      r[32*c+24 +: 8] = a3 ^ t ^ xt(a3 ^ a0);
    end
    return r;
  endfunction

  function automatic logic [7:0] mul9(input logic [7:0] a);
    return xt(xt(xt(a))) ^ a;
  endfunction

  function automatic logic [7:0] mul11(input logic [7:0] a);
    return xt(xt(xt(a))) ^ xt(a) ^ a;
  endfunction

  function automatic logic [7:0] mul13(input logic [7:0] a);
    return xt(xt(xt(a))) ^ xt(xt(a)) ^ a;
  endfunction

  function automatic logic [7:0] mul14(input logic [7:0] a);
    return xt(xt(xt(a))) ^ xt(xt(a)) ^ xt(a);
  endfunction

  function automatic logic [127:0] inv_mix_cols(input logic [127:0] s);
    logic [127:0] r;
    logic [7:0] a0, a1, a2, a3;
    for (int c = 0; c < 4; c++) begin
      a0 = s[32*c +: 8];
      a1 = s[32*c+8 +: 8];
      a2 = s[32*c+16 +: 8];
      a3 = s[32*c+24 +: 8];
      r[32*c +: 8]    = mul14(a0) ^ mul11(a1) ^ mul13(a2) ^ mul9(a3);
      r[32*c+8 +: 8]  = mul9(a0) ^ mul14(a1) ^ mul11(a2) ^ mul13(a3);
      r[32*c+16 +: 8] = mul13(a0) ^ mul9(a1) ^ mul14(a2) ^ mul11(a3);
      r[32*c+24 +: 8] = mul11(a0) ^ mul13(a1) ^ mul9(a2) ^ mul14(a3);
    end
    return r;
  endfunction

  // Byte (row, col) sits at index row + 4*col; rows rotate left by their row number.
  function automatic logic [127:0] sub_shift(input logic [127:0] s);
    logic [127:0] r;
    logic [1:0] sc;
    for (int row = 0; row < 4; row++) begin
      for (int col = 0; col < 4; col++) begin
        sc = 2'(col + row);
        r[8*(row + 4*col) +: 8] = SBOX[s[8*(row + 4*int'(sc)) +: 8]];
      end
    end
    return r;
  endfunction

  function automatic logic [127:0] inv_sub_shift(input logic [127:0] s);
    logic [127:0] r;
    logic [1:0] dc;
    for (int row = 0; row < 4; row++) begin
      for (int col = 0; col < 4; col++) begin
        dc = 2'(col + row);
        r[8*(row + 4*int'(dc)) +: 8] = INV_SBOX[s[8*(row + 4*col) +: 8]];
      end
    end
    return r;
  endfunction

  function automatic logic [127:0] key_next(input logic [127:0] k, input logic [7:0] rc);
    logic [31:0] t, n0, n1, n2, n3;
    t  = {SBOX[k[103:96]], SBOX[k[127:120]], SBOX[k[119:112]], SBOX[k[111:104]] ^ rc};
    n0 = k[31:0] ^ t;
    n1 = k[63:32] ^ n0;
    n2 = k[95:64] ^ n1;
    n3 = k[127:96] ^ n2;
    return {n3, n2, n1, n0};
  endfunction

endpackage
`default_nettype wire

// ----- design/aes128_ram.sv -----
`default_nettype none
module aes128_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- design/aes128_block_cipher.sv -----
`default_nettype none
// AES-128 single-block encrypt/decrypt engine.
// Input channel: in_valid / in_stall / in_data (kind, block). kind 0 encrypts,
// kind 1 decrypts. Output channel: out_valid / out_stall / out_data.
// Key: write key_low (index 0) or key_high (index 1) through cfg_we, cfg_index
// and cfg_data. Each write restarts the key schedule, which produces one
// round key per cycle from a shared expansion step, with the InvMixColumns
// image of round keys 1 to 9 written to a second store for decryption.
// Reset clears the key to zero and runs the same expansion; in_stall is high
// until it finishes.
// An item occupies the block from the accepting edge until its result is out:
// one round per cycle through a single shared round unit (initial key add,
// 9 full rounds, final round). The block takes no new item until the result
// of the last one has been registered onto out_valid.
// If the receiver still stalls a previous result, the finished item waits in
// the state register and in_stall stays high until it can be moved out.
module aes128_block_cipher (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire aes128_pkg::in_t  in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output aes128_pkg::out_t      out_data,
  input  wire logic             cfg_we,
  input  wire logic             cfg_index,
  input  wire logic [63:0]      cfg_data
);

  aes128_pkg::state_t state, state_next;

  logic [63:0]  key_low, key_high;
  logic [127:0] rk;
  logic [7:0]   rcon;
  logic [3:0]   count;
  logic [127:0] st;
  logic         kind_r;
  logic         key_sel_dec;

  logic [127:0] key_new;
  logic [127:0] round_in, round_out, round_key;
  logic [127:0] enc_rdata, dec_rdata;
  logic [3:0]   n;
  logic         kind_sel;
  logic [aes128_pkg::ENC_AW-1:0] enc_raddr, enc_waddr;
  logic [aes128_pkg::DEC_AW-1:0] dec_raddr, dec_waddr;
  logic         enc_we, dec_we;
  logic         accept, last, out_free;

  assign key_new = cfg_index ? {cfg_data, key_low} : {key_high, cfg_data};
  assign in_stall = (state != aes128_pkg::ST_IDLE);
  assign accept = in_valid && !in_stall;
  assign last = (count == 4'(aes128_pkg::ROUNDS));
  assign out_free = !out_valid || !out_stall;

  // Key read for round n is issued in the cycle before that round.
  assign n = (state == aes128_pkg::ST_IDLE) ? 4'd0 : count + 4'd1;
  assign kind_sel = (state == aes128_pkg::ST_IDLE) ? in_data.kind : kind_r;

  always_comb begin
    if (kind_sel) begin
      enc_raddr = (n == 4'd0) ? aes128_pkg::ENC_AW'(aes128_pkg::ROUNDS) : '0;
    end else begin
      enc_raddr = n[aes128_pkg::ENC_AW-1:0];
    end
  end
  assign dec_raddr = aes128_pkg::DEC_AW'(n - 4'd1);

  assign enc_we = (state == aes128_pkg::ST_EXPAND) && !cfg_we;
  assign dec_we = enc_we && (count >= 4'd1) && (count <= 4'(aes128_pkg::DEC_KEYS));
  assign enc_waddr = count[aes128_pkg::ENC_AW-1:0];
  assign dec_waddr = aes128_pkg::DEC_AW'(4'(aes128_pkg::DEC_KEYS) - count);

  aes128_ram #(.WIDTH(128), .DEPTH(aes128_pkg::ENC_KEYS)) u_enc_ram (
    .clk   (clk),
    .we    (enc_we),
    .waddr (enc_waddr),
    .wdata (rk),
    .raddr (enc_raddr),
    .rdata (enc_rdata)
  );

  aes128_ram #(.WIDTH(128), .DEPTH(aes128_pkg::DEC_KEYS)) u_dec_ram (
    .clk   (clk),
    .we    (dec_we),
    .waddr (dec_waddr),
    .wdata (aes128_pkg::inv_mix_cols(rk)),
    .raddr (dec_raddr),
    .rdata (dec_rdata)
  );

  // Shared round unit.
  always_comb begin
    if (count == 4'd0) begin
      round_in = st;
    end else if (!kind_r) begin
      round_in = last ? aes128_pkg::sub_shift(st)
                      : aes128_pkg::mix_cols(aes128_pkg::sub_shift(st));
    end else begin
      round_in = last ? aes128_pkg::inv_sub_shift(st)
                      : aes128_pkg::inv_mix_cols(aes128_pkg::inv_sub_shift(st));
    end
    round_key = key_sel_dec ? dec_rdata : enc_rdata;
    round_out = round_in ^ round_key;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= aes128_pkg::ST_EXPAND;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      aes128_pkg::ST_EXPAND: begin
        if (last) state_next = aes128_pkg::ST_IDLE;
      end
      aes128_pkg::ST_IDLE: begin
        if (accept) state_next = aes128_pkg::ST_RUN;
      end
      aes128_pkg::ST_RUN: begin
        if (last) state_next = out_free ? aes128_pkg::ST_IDLE : aes128_pkg::ST_HOLD;
      end
      aes128_pkg::ST_HOLD: begin
        if (out_free) state_next = aes128_pkg::ST_IDLE;
      end
      default: state_next = aes128_pkg::ST_EXPAND;
    endcase
    if (cfg_we) state_next = aes128_pkg::ST_EXPAND;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_low   <= '0;
      key_high  <= '0;
      rk        <= '0;
      rcon      <= aes128_pkg::RCON_FIRST;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      key_sel_dec <= kind_sel && (n >= 4'd1) && (n <= 4'(aes128_pkg::DEC_KEYS));
      if (cfg_we) begin
        if (cfg_index) begin
          key_high <= cfg_data;
        end else begin
          key_low <= cfg_data;
        end
        rk    <= key_new;
        rcon  <= aes128_pkg::RCON_FIRST;
        count <= '0;
      end else begin
        unique case (state)
          aes128_pkg::ST_EXPAND: begin
            rk    <= aes128_pkg::key_next(rk, rcon);
            rcon  <= aes128_pkg::xt(rcon);
            count <= count + 4'd1;
          end
          aes128_pkg::ST_IDLE: begin
            if (accept) begin
              st     <= {in_data.block_high, in_data.block_low};
              kind_r <= in_data.kind;
              count  <= '0;
            end
          end
          aes128_pkg::ST_RUN: begin
            st    <= round_out;
            count <= count + 4'd1;
          end
          aes128_pkg::ST_HOLD: begin
          end
          default: begin
          end
        endcase
      end

      if (state == aes128_pkg::ST_RUN && last && out_free) begin
        out_valid <= 1'b1;
        out_data  <= round_out;
      end else if (state == aes128_pkg::ST_HOLD && out_free) begin
        out_valid <= 1'b1;
        out_data  <= st;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ----- sim/testbench.sv -----
`timescale 1ns / 100ps
module testbench;

  localparam int DRAIN_CYCLES = 16;
  localparam int STALL_LIMIT  = 5000;
  localparam int HOLD_CYCLES  = 300;
  localparam logic KEY_LOW_REG  = 1'b0;
  localparam logic KEY_HIGH_REG = 1'b1;
  localparam logic KIND_ENC = 1'b0;
  localparam logic KIND_DEC = 1'b1;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  aes128_pkg::in_t   in_data;
  logic              out_valid;
  logic              out_stall;
  aes128_pkg::out_t  out_data;
  logic              cfg_we;
  logic              cfg_index;
  logic [63:0]       cfg_data;

  aes128_block_cipher i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  typedef struct {
    bit          load_key;
    logic [63:0] key_lo;
    logic [63:0] key_hi;
    logic        kind;
    logic [63:0] blk_lo;
    logic [63:0] blk_hi;
    bit          known;
    logic [63:0] res_lo;
    logic [63:0] res_hi;
  } vector_t;

  logic [63:0]      cur_key_lo, cur_key_hi;
  aes128_pkg::out_t pending_blocks[$];
  int               send_idle_pct, recv_idle_pct;
  bit               hold_req;
  int               errors, n_enc, n_dec, n_keys, n_results;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------- predictor ----------------
  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    p = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p ^= a;
      a = xtime(a);
    end
    return p;
  endfunction

  function automatic void expand_round_keys(input logic [127:0] key,
                                            output logic [127:0] rk [11]);
    logic [31:0] w [44];
    logic [31:0] t;
    logic [7:0]  rc;
    rc = 8'h01;
    for (int i = 0; i < 4; i++) w[i] = key[32*i +: 32];
    for (int i = 4; i < 44; i++) begin
      t = w[i-1];
      if (i % 4 == 0) begin
        // Rotate one byte toward byte 0, substitute, fold in the round constant.
        t = {aes128_pkg::SBOX[t[7:0]], aes128_pkg::SBOX[t[31:24]],
             aes128_pkg::SBOX[t[23:16]], aes128_pkg::SBOX[t[15:8]] ^ rc};
        rc = xtime(rc);
      end
      w[i] = w[i-4] ^ t;
    end
    for (int r = 0; r < 11; r++) rk[r] = {w[4*r+3], w[4*r+2], w[4*r+1], w[4*r]};
  endfunction

  function automatic logic [127:0] fwd_sub_rows(input logic [127:0] s);
    logic [127:0] o;
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++)
        o[8*(r+4*c) +: 8] = aes128_pkg::SBOX[s[8*(r+4*((c+r)%4)) +: 8]];
    return o;
  endfunction

  function automatic logic [127:0] rev_sub_rows(input logic [127:0] s);
    logic [127:0] o;
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++)
        o[8*(r+4*((c+r)%4)) +: 8] = aes128_pkg::INV_SBOX[s[8*(r+4*c) +: 8]];
    return o;
  endfunction

  function automatic logic [127:0] mix_columns(input logic [127:0] s, input bit inverse);
    logic [127:0] o;
    logic [7:0] a [4];
    logic [7:0] m [4];
    if (inverse) begin
      m = '{8'd14, 8'd11, 8'd13, 8'd9};
    end else begin
      m = '{8'd2, 8'd3, 8'd1, 8'd1};
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) a[r] = s[8*(r+4*c) +: 8];
      for (int r = 0; r < 4; r++)
        o[8*(r+4*c) +: 8] = gf_mul(a[r], m[0]) ^ gf_mul(a[(r+1)%4], m[1])
                          ^ gf_mul(a[(r+2)%4], m[2]) ^ gf_mul(a[(r+3)%4], m[3]);
    end
    return o;
  endfunction

  function automatic aes128_pkg::out_t cipher_block(input aes128_pkg::in_t item);
    logic [127:0] rk [11];
    logic [127:0] s;
    aes128_pkg::out_t res;
    expand_round_keys({cur_key_hi, cur_key_lo}, rk);
    s = {item.block_high, item.block_low};
    if (item.kind == KIND_ENC) begin
      s ^= rk[0];
      for (int r = 1; r < 10; r++) s = mix_columns(fwd_sub_rows(s), 1'b0) ^ rk[r];
      s = fwd_sub_rows(s) ^ rk[10];
    end else begin
      s ^= rk[10];
      for (int r = 9; r >= 1; r--) s = mix_columns(rev_sub_rows(s) ^ rk[r], 1'b1);
      s = rev_sub_rows(s) ^ rk[0];
    end
    res.result_high = s[127:64];
    res.result_low  = s[63:0];
    return res;
  endfunction

  // ---------------- monitor, checker and watchdog ----------------
  int quiet_cycles;
  always @(posedge clk) begin
    aes128_pkg::out_t want;
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        pending_blocks.push_back(cipher_block(in_data));
        if (in_data.kind == KIND_ENC) n_enc++;
        else n_dec++;
      end
      if (out_valid && !out_stall) begin
        n_results++;
        if (pending_blocks.size() == 0) begin
          $error("unexpected result %h %h", out_data.result_high, out_data.result_low);
          errors++;
        end else begin
          want = pending_blocks.pop_front();
          if (out_data.result_low !== want.result_low) begin
            $error("result_low: expected %h, actual %h", want.result_low, out_data.result_low);
            errors++;
          end
          if (out_data.result_high !== want.result_high) begin
            $error("result_high: expected %h, actual %h", want.result_high,
                   out_data.result_high);
            errors++;
          end
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    int held;
    out_stall = 1'b1;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        for (held = 0; held < HOLD_CYCLES; held++) begin
          out_stall <= 1'b1;
          @(posedge clk);
        end
        hold_req = 1'b0;
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
      @(posedge clk);
    end
  end

  // ---------------- stimulus ----------------
  task automatic send_block(input logic kind, input logic [63:0] lo, input logic [63:0] hi);
    aes128_pkg::in_t item;
    item.kind = kind;
    item.block_low = lo;
    item.block_high = hi;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_results_done;
    in_valid <= 1'b0;
    while (pending_blocks.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_key_reg(input logic idx, input logic [63:0] val);
    wait_results_done();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == KEY_LOW_REG) cur_key_lo = val;
    else cur_key_hi = val;
    n_keys++;
    @(posedge clk);
  endtask

  function automatic logic [63:0] rand_word;
    case ($urandom_range(9))
      0: return 64'h0;
      1: return '1;
      2: return 64'h8080808080808080;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  vector_t directed [12] = '{
    // Reset key of all zeros.
    '{0, 0, 0, KIND_ENC, 64'h0, 64'h0, 1, 64'h3b2c8aefd44be966, 64'h2e2b34ca59fa4c88},
    '{0, 0, 0, KIND_DEC, 64'h3b2c8aefd44be966, 64'h2e2b34ca59fa4c88, 1, 64'h0, 64'h0},
    '{0, 0, 0, KIND_ENC, '1, '1, 0, 0, 0},
    '{0, 0, 0, KIND_DEC, '1, '1, 0, 0, 0},
    // Standard example key and block.
    '{1, 64'h0706050403020100, 64'h0f0e0d0c0b0a0908, KIND_ENC,
      64'h7766554433221100, 64'hffeeddccbbaa9988, 1, 64'h30047b6ad8e0c469, 64'h5ac5b47080b7cdd8},
    '{0, 0, 0, KIND_DEC, 64'h30047b6ad8e0c469, 64'h5ac5b47080b7cdd8, 1,
      64'h7766554433221100, 64'hffeeddccbbaa9988},
    '{0, 0, 0, KIND_ENC, 64'h0, 64'h0, 0, 0, 0},
    '{0, 0, 0, KIND_DEC, 64'h8000000000000000, 64'h1, 0, 0, 0},
    // All-ones key.
    '{1, '1, '1, KIND_ENC, 64'h0, 64'h0, 0, 0, 0},
    '{0, 0, 0, KIND_ENC, '1, '1, 0, 0, 0},
    '{0, 0, 0, KIND_DEC, '1, 64'h0, 0, 0, 0},
    '{0, 0, 0, KIND_DEC, 64'h0123456789abcdef, 64'hfedcba9876543210, 0, 0, 0}
  };

  initial begin
    vector_t v;
    aes128_pkg::out_t typed;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = KEY_LOW_REG;
    cfg_data = '0;
    hold_req = 1'b0;
    cur_key_lo = '0;
    cur_key_hi = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table; typed-in results must agree with the predictor too.
    foreach (directed[i]) begin
      v = directed[i];
      if (v.load_key) begin
        write_key_reg(KEY_LOW_REG, v.key_lo);
        write_key_reg(KEY_HIGH_REG, v.key_hi);
      end
      if (v.known) begin
        typed = cipher_block(aes128_pkg::in_t'{kind: v.kind, block_high: v.blk_hi,
                                               block_low: v.blk_lo});
        if (typed.result_low !== v.res_lo || typed.result_high !== v.res_hi) begin
          $error("known vector %0d: expected %h %h, predicted %h %h", i, v.res_hi, v.res_lo,
                 typed.result_high, typed.result_low);
          errors++;
        end
      end
      send_block(v.kind, v.blk_lo, v.blk_hi);
    end

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 27 : (ph == 1) ? 53 : 0;
      recv_idle_pct = (ph == 0) ? 53 : (ph == 1) ? 27 : 0;
      for (int n = 0; n < 630; n++) begin
        if (n % 150 == 0) begin
          if (n == 300) begin
            write_key_reg(KEY_LOW_REG, rand_word());
          end else begin
            write_key_reg(KEY_LOW_REG, rand_word());
            write_key_reg(KEY_HIGH_REG, rand_word());
          end
        end
        // Long receiver hold-off while blocks keep coming.
        if (n == 40 && ph == 2) hold_req = 1'b1;
        // Sender pause until everything is back.
        if (n == 500) wait_results_done();
        send_block(1'($urandom_range(1)), rand_word(), rand_word());
      end
    end

    wait_results_done();
    $display("Ran %0d encryptions and %0d decryptions under %0d key register writes,",
             n_enc, n_dec, n_keys);
    $display("with idle and stall mixes on both channels; %0d results checked.", n_results);
    if (errors == 0 && pending_blocks.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/aes128_pkg.sv
design/aes128_ram.sv
design/aes128_block_cipher.sv
sim/testbench.sv
